FILE: rtl/cffdict_pkg.sv
package cffdict_pkg;

  // Token kinds carried on the result channel.
  typedef enum logic [1:0] {
    KindOperator = 2'd0,
    KindInteger  = 2'd1,
    KindReal     = 2'd2,
    KindError    = 2'd3
  } token_kind_e;

  // Lead byte codes and biases of the DICT operand encoding.
  localparam logic [7:0] OpCodeMax    = 8'd21;
  localparam logic [7:0] LeadInt16    = 8'd28;
  localparam logic [7:0] LeadInt32    = 8'd29;
  localparam logic [7:0] LeadReal     = 8'd30;
  localparam logic [7:0] OneByteLo    = 8'd32;
  localparam logic [7:0] OneByteHi    = 8'd246;
  localparam logic [7:0] TwoPosLo     = 8'd247;
  localparam logic [7:0] TwoPosHi     = 8'd250;
  localparam logic [7:0] TwoNegLo     = 8'd251;
  localparam logic [7:0] TwoNegHi     = 8'd254;
  localparam logic [7:0] OneByteBias  = 8'd139;
  localparam logic [7:0] TwoByteBias  = 8'd108;
  localparam logic [3:0] NibbleEnd    = 4'hF;

  typedef struct packed {
    token_kind_e        kind;
    logic [4:0]         op_code;
    logic signed [31:0] value;
  } token_t;

endpackage

FILE: rtl/cffdict_if.sv
interface cffdict_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_dict;

  modport source (output valid, output data_byte, output end_of_dict, input ready);
  modport sink (input valid, input data_byte, input end_of_dict, output ready);
endinterface

interface cffdict_token_if;
  logic               valid;
  logic               ready;
  logic [1:0]         token_kind;
  logic [4:0]         operator_code;
  logic signed [31:0] int_value;

  modport source (output valid, output token_kind, output operator_code, output int_value,
                  input ready);
  modport sink (input valid, input token_kind, input operator_code, input int_value,
                output ready);
endinterface

FILE: rtl/cff_dict_token_decoder_top.sv
// CFF DICT token decoder. Bytes of a DICT arrive one per transaction on
// byte_i, with end_of_dict set on the last byte of the buffer; each completed
// operator, integer operand, real operand (reported without its value) or
// format error leaves as one token transaction on token_o. Middle bytes of a
// multi-byte operand produce no token. The block takes one byte every clock
// cycle as long as the token side keeps up; a byte passes an input register
// and the decode logic, and its token is written into the result register.
// A stall on token_o holds the input side only once both registers are
// full.
module cff_dict_token_decoder_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  cffdict_byte_if.sink     byte_i,
  cffdict_token_if.source  token_o
);
  import cffdict_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic       out_valid_q, out_valid_d;
  token_t     out_tok_q;

  logic       step;
  logic       emit;
  token_t     tok;

  // The decode step runs when a byte is held and the result register is free.
  assign step         = in_valid_q && (!out_valid_q || token_o.ready);
  assign byte_i.ready = !in_valid_q || step;
  assign out_valid_d  = (step && emit) || (out_valid_q && !token_o.ready);

  cffdict_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_byte_q),
    .end_of_dict_i(in_last_q),
    .emit_o       (emit),
    .token_o      (tok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.end_of_dict;
    end
    if (step && emit) begin
      out_tok_q <= tok;
    end
  end

  assign token_o.valid         = out_valid_q;
  assign token_o.token_kind    = out_tok_q.kind;
  assign token_o.operator_code = out_tok_q.op_code;
  assign token_o.int_value     = out_tok_q.value;

`ifndef SYNTHESIS
  // A held byte must not be lost while the result register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !token_o.ready) |=> in_valid_q)
    else $error("held byte dropped during output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tok_q.kind != KindInteger) |-> (out_tok_q.value == 32'sd0))
    else $error("int_value nonzero on a non-integer token");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tok_q.kind != KindOperator) |-> (out_tok_q.op_code == 5'd0))
    else $error("operator_code nonzero on a non-operator token");

  // Without a decode step the result register cannot gain a new token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !step) |=> !out_valid_q)
    else $error("token produced without a decode step");
`endif

endmodule

FILE: rtl/cffdict_parser.sv
module cffdict_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_dict_i,
  output logic                emit_o,
  output cffdict_pkg::token_t token_o
);
  import cffdict_pkg::*;

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeInt  = 2'd1;
  localparam logic [1:0] ModeReal = 2'd2;

  logic [1:0]  mode_q, mode_d;
  logic [2:0]  left_q, left_d;
  logic [7:0]  lead_q, lead_d;
  logic [31:0] accum_q, accum_d;

  logic [31:0] shifted;
  logic [2:0]  left_dec;
  logic [1:0]  two_idx;
  logic [10:0] two_mag;
  logic [31:0] int_done;
  logic [7:0]  b;

  assign b        = data_byte_i;
  assign shifted  = {accum_q[23:0], b};
  assign left_dec = (left_q != 3'd0) ? left_q - 3'd1 : left_q;
  // The two-byte forms use (lead - 247) or (lead - 251), which is the low two
  // bits of the lead byte plus one.
  assign two_idx  = lead_q[1:0] + 2'd1;
  assign two_mag  = {1'b0, two_idx, b} + {3'd0, TwoByteBias};

  always_comb begin
    if (lead_q inside {[TwoPosLo:TwoPosHi]}) begin
      int_done = {21'd0, two_mag};
    end else if (lead_q inside {[TwoNegLo:TwoNegHi]}) begin
      int_done = 32'd0 - {21'd0, two_mag};
    end else if (lead_q == LeadInt16) begin
      int_done = {{16{accum_q[7]}}, accum_q[7:0], b};
    end else begin
      int_done = shifted;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    left_d  = left_q;
    lead_d  = lead_q;
    accum_d = accum_q;
    emit_o  = 1'b0;
    token_o = '{kind: KindError, op_code: 5'd0, value: 32'sd0};
    case (mode_q)
      ModeInt: begin
        accum_d = shifted;
        left_d  = left_dec;
        if (left_dec == 3'd0) begin
          emit_o        = 1'b1;
          token_o.kind  = KindInteger;
          token_o.value = int_done;
          mode_d        = ModeIdle;
          lead_d        = 8'd0;
          accum_d       = 32'd0;
        end else if (end_of_dict_i) begin
          emit_o  = 1'b1;
          mode_d  = ModeIdle;
          left_d  = 3'd0;
          lead_d  = 8'd0;
          accum_d = 32'd0;
        end
      end
      ModeReal: begin
        if (b[7:4] == NibbleEnd || b[3:0] == NibbleEnd) begin
          emit_o       = 1'b1;
          token_o.kind = KindReal;
          mode_d       = ModeIdle;
        end else if (end_of_dict_i) begin
          emit_o = 1'b1;
          mode_d = ModeIdle;
        end
      end
      default: begin
        // Idle, and the unused mode code: the byte is a lead byte.
        mode_d  = ModeIdle;
        left_d  = 3'd0;
        lead_d  = 8'd0;
        accum_d = 32'd0;
        if (b <= OpCodeMax) begin
          emit_o          = 1'b1;
          token_o.kind    = KindOperator;
          token_o.op_code = b[4:0];
        end else if (b inside {[OneByteLo:OneByteHi]}) begin
          emit_o        = 1'b1;
          token_o.kind  = KindInteger;
          token_o.value = {24'd0, b} - {24'd0, OneByteBias};
        end else if (b == LeadInt16 || b == LeadInt32 || b inside {[TwoPosLo:TwoNegHi]}) begin
          if (end_of_dict_i) begin
            emit_o = 1'b1;
          end else begin
            mode_d = ModeInt;
            lead_d = b;
            if (b == LeadInt16) begin
              left_d = 3'd2;
            end else if (b == LeadInt32) begin
              left_d = 3'd4;
            end else begin
              left_d = 3'd1;
            end
          end
        end else if (b == LeadReal) begin
          if (end_of_dict_i) begin
            emit_o = 1'b1;
          end else begin
            mode_d = ModeReal;
          end
        end else begin
          emit_o = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      left_q  <= 3'd0;
      lead_q  <= 8'd0;
      accum_q <= 32'd0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      left_q  <= left_d;
      lead_q  <= lead_d;
      accum_q <= accum_d;
    end
  end

endmodule
